### hdl/icmp_rtt_pkg.sv
// ----------------------------------------------------------------------------
// icmp_rtt_pkg
// Shared constants, codes and stage bundles of the ICMP echo-reply RTT block.
// ----------------------------------------------------------------------------
`default_nettype none

package icmp_rtt_pkg;

  // Field widths
  localparam int POS_W            = 16;  // packet byte position counter
  localparam int TIME_FIELD_BYTES = 8;   // bytes per timestamp field
  localparam int HDR_W            = 6;   // IP header length in bytes
  localparam int SEC_W            = 32;
  localparam int US_W             = 20;
  localparam int RTT_W            = 32;
  localparam int TOTAL_W          = 48;
  localparam int COUNT_W          = 32;
  localparam int ID_W             = 16;
  localparam int ADDR_W           = 32;

  // Stream word layout
  localparam int IN_TDATA_W   = 64;
  localparam int OUT_TDATA_W  = 176;
  localparam int OUT_TUSER_W  = 4;
  localparam int CFG_ADDR_W   = 1;
  localparam int CFG_DATA_W   = 32;

  // Byte offsets inside the ICMP part
  localparam int OFF_TYPE       = 0;
  localparam int OFF_ID_LO      = 4;
  localparam int OFF_ID_HI      = 5;
  localparam int OFF_SEC        = 8;
  localparam int OFF_USEC       = OFF_SEC + TIME_FIELD_BYTES;
  localparam int MIN_ICMP_BYTES = OFF_USEC + TIME_FIELD_BYTES;
  localparam int OFF_W          = $clog2(MIN_ICMP_BYTES);
  localparam int SEC_BYTES      = SEC_W / 8;
  localparam int USEC_BYTES     = (US_W + 7) / 8;
  localparam int USEC_PAD_W     = USEC_BYTES * 8;

  // Source address bytes inside the IP header
  localparam int SRC_FIRST = 12;
  localparam int SRC_LAST  = 15;

  localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;

  // Round-trip arithmetic
  localparam int USEC_PER_SEC = 1000000;
  localparam int MS_PER_SEC   = 1000;
  localparam int US_PER_MS    = 1000;
  localparam int MS_W         = 45;  // signed milliseconds before clamping
  localparam int RECIP_SHIFT  = 30;
  localparam int RECIP_W      = 21;
  localparam longint USEC_RECIP = ((64'd1 << RECIP_SHIFT) + US_PER_MS - 1) / US_PER_MS;
  localparam int QP_W         = US_W + RECIP_W;
  localparam int Q_W          = 11;  // quotient of a 20-bit value by 1000

  typedef enum logic [2:0] {
    VERDICT_OK,
    VERDICT_SHORT,
    VERDICT_TYPE,
    VERDICT_ID,
    VERDICT_SRC
  } verdict_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_EXPECTED_ID,
    REG_EXPECTED_SOURCE
  } cfg_reg_t;

  // Fields captured for one packet, handed over on its last byte
  typedef struct packed {
    logic              too_short;
    logic [7:0]        reply_type;
    logic [ID_W-1:0]   reply_id;
    logic [ADDR_W-1:0] source;
    logic [SEC_W-1:0]  sent_sec;
    logic [US_W-1:0]   sent_usec;
    logic [SEC_W-1:0]  recv_sec;
    logic [US_W-1:0]   recv_usec;
  } job_t;

  // Checked packet with its round trip
  typedef struct packed {
    verdict_t         verdict;
    logic [RTT_W-1:0] rtt;
  } res_t;

endpackage

`default_nettype wire

### hdl/icmp_rtt_parse.sv
// ----------------------------------------------------------------------------
// icmp_rtt_parse
// Byte-wise packet parser: tracks position and captures header fields.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp_rtt_parse (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic [7:0]                     in_byte,
  input  wire logic                           in_last,
  input  wire logic [icmp_rtt_pkg::SEC_W-1:0] in_sec,
  input  wire logic [icmp_rtt_pkg::US_W-1:0]  in_usec,
  output logic                                in_ready,
  output logic                                job_valid_r,
  output icmp_rtt_pkg::job_t                  job_r,
  input  wire logic                           job_ready
);

  logic [icmp_rtt_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic [icmp_rtt_pkg::HDR_W-1:0]      hdr_r, hdr_nxt;
  logic [7:0]                          type_r, type_nxt;
  logic [icmp_rtt_pkg::ID_W-1:0]       id_r, id_nxt;
  logic [icmp_rtt_pkg::ADDR_W-1:0]     src_r, src_nxt;
  logic [icmp_rtt_pkg::SEC_W-1:0]      sec_r, sec_nxt;
  logic [icmp_rtt_pkg::US_W-1:0]       usec_r, usec_nxt;
  logic [icmp_rtt_pkg::USEC_PAD_W-1:0] usec_wide;
  logic [icmp_rtt_pkg::POS_W:0]        rel;
  logic [icmp_rtt_pkg::POS_W:0]        len;
  logic [icmp_rtt_pkg::POS_W:0]        need;
  logic [icmp_rtt_pkg::OFF_W-1:0]      off;
  logic [1:0]                          sec_k;
  logic [1:0]                          usec_k;
  logic                                near;
  logic                                accept;
  icmp_rtt_pkg::job_t                  job_nxt;

  assign in_ready = !job_valid_r || job_ready;
  assign accept   = in_valid && in_ready;

  // Place captures relative to the ICMP header start
  always_comb begin
    hdr_nxt = (pos_r == '0) ? {in_byte[3:0], 2'b00} : hdr_r;
    rel     = {1'b0, pos_r} - (icmp_rtt_pkg::POS_W+1)'(hdr_nxt);
    near    = !rel[icmp_rtt_pkg::POS_W] &&
              (rel[icmp_rtt_pkg::POS_W-1:0] <
               icmp_rtt_pkg::POS_W'(icmp_rtt_pkg::MIN_ICMP_BYTES));
    off     = rel[icmp_rtt_pkg::OFF_W-1:0];
    sec_k   = 2'(off - icmp_rtt_pkg::OFF_W'(icmp_rtt_pkg::OFF_SEC));
    usec_k  = 2'(off - icmp_rtt_pkg::OFF_W'(icmp_rtt_pkg::OFF_USEC));

    type_nxt  = type_r;
    id_nxt    = id_r;
    src_nxt   = src_r;
    sec_nxt   = sec_r;
    usec_wide = icmp_rtt_pkg::USEC_PAD_W'(usec_r);

    // Source address, first byte on the wire is the most significant
    if (pos_r >= icmp_rtt_pkg::POS_W'(icmp_rtt_pkg::SRC_FIRST) &&
        pos_r <= icmp_rtt_pkg::POS_W'(icmp_rtt_pkg::SRC_LAST)) begin
      src_nxt[{~pos_r[1:0], 3'b000} +: 8] = in_byte;
    end
    if (near && off == icmp_rtt_pkg::OFF_W'(icmp_rtt_pkg::OFF_TYPE)) begin
      type_nxt = in_byte;
    end
    if (near && off == icmp_rtt_pkg::OFF_W'(icmp_rtt_pkg::OFF_ID_LO)) begin
      id_nxt[7:0] = in_byte;
    end
    if (near && off == icmp_rtt_pkg::OFF_W'(icmp_rtt_pkg::OFF_ID_HI)) begin
      id_nxt[15:8] = in_byte;
    end
    // Low bytes of the little-endian seconds field
    if (near && off >= icmp_rtt_pkg::OFF_W'(icmp_rtt_pkg::OFF_SEC) &&
        off < icmp_rtt_pkg::OFF_W'(icmp_rtt_pkg::OFF_SEC + icmp_rtt_pkg::SEC_BYTES)) begin
      sec_nxt[{sec_k, 3'b000} +: 8] = in_byte;
    end
    // Low bytes of the little-endian microseconds field
    if (near && off >= icmp_rtt_pkg::OFF_W'(icmp_rtt_pkg::OFF_USEC) &&
        off < icmp_rtt_pkg::OFF_W'(icmp_rtt_pkg::OFF_USEC + icmp_rtt_pkg::USEC_BYTES)) begin
      usec_wide[{usec_k, 3'b000} +: 8] = in_byte;
    end
    usec_nxt = usec_wide[icmp_rtt_pkg::US_W-1:0];

    // Advance position, saturating; restart after the last byte
    if (in_last) begin
      pos_nxt = '0;
    end else if (pos_r != '1) begin
      pos_nxt = pos_r + 1'b1;
    end else begin
      pos_nxt = pos_r;
    end

    len  = {1'b0, pos_r} + 1'b1;
    need = (icmp_rtt_pkg::POS_W+1)'(hdr_nxt) +
           (icmp_rtt_pkg::POS_W+1)'(icmp_rtt_pkg::MIN_ICMP_BYTES);

    job_nxt.too_short  = len < need;
    job_nxt.reply_type = type_nxt;
    job_nxt.reply_id   = id_nxt;
    job_nxt.source     = src_nxt;
    job_nxt.sent_sec   = sec_nxt;
    job_nxt.sent_usec  = usec_nxt;
    job_nxt.recv_sec   = in_sec;
    job_nxt.recv_usec  = in_usec;
  end

  // Hold captured fields across packets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      hdr_r       <= '0;
      type_r      <= '0;
      id_r        <= '0;
      src_r       <= '0;
      sec_r       <= '0;
      usec_r      <= '0;
      job_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        pos_r  <= pos_nxt;
        hdr_r  <= hdr_nxt;
        type_r <= type_nxt;
        id_r   <= id_nxt;
        src_r  <= src_nxt;
        sec_r  <= sec_nxt;
        usec_r <= usec_nxt;
      end
      if (in_ready) begin
        job_valid_r <= accept && in_last;
      end
    end
  end

  // Launch a job on the last byte
  always_ff @(posedge clk) begin
    if (accept && in_last) begin
      job_r <= job_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/icmp_rtt_calc.sv
// ----------------------------------------------------------------------------
// icmp_rtt_calc
// Reply checks and round-trip arithmetic in three pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp_rtt_calc (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [icmp_rtt_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [icmp_rtt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                                job_valid,
  input  wire icmp_rtt_pkg::job_t                  job,
  output logic                                     job_ready,
  output logic                                     res_valid_r,
  output icmp_rtt_pkg::res_t                       res_r,
  input  wire logic                                res_ready
);

  logic [icmp_rtt_pkg::ID_W-1:0]   exp_id_r;
  logic [icmp_rtt_pkg::ADDR_W-1:0] exp_src_r;

  // Stage 2: verdict and time differences
  logic                            v2_r, ready2;
  icmp_rtt_pkg::verdict_t          verdict2_r, verdict2_nxt;
  logic [icmp_rtt_pkg::SEC_W+1:0]  s2_r, s2_nxt;
  logic [icmp_rtt_pkg::US_W:0]     us2_r, us2_nxt, us_diff;

  // Stage 3: products
  logic                            v3_r, ready3;
  icmp_rtt_pkg::verdict_t          verdict3_r;
  logic [icmp_rtt_pkg::MS_W-1:0]   s1000_r, s1000_nxt;
  logic [icmp_rtt_pkg::QP_W-1:0]   qp_r, qp_nxt;
  logic                            neg3_r;
  logic [icmp_rtt_pkg::US_W:0]     us_neg;
  logic [icmp_rtt_pkg::US_W-1:0]   us_mag;

  // Stage 4: sum and clamp
  logic                            ready4;
  logic [icmp_rtt_pkg::Q_W-1:0]    q;
  logic [icmp_rtt_pkg::MS_W-1:0]   q_ext, q_s, ms;
  icmp_rtt_pkg::res_t              res_nxt;

  assign ready4    = !res_valid_r || res_ready;
  assign ready3    = !v3_r || ready4;
  assign ready2    = !v2_r || ready3;
  assign job_ready = ready2;

  // Write match registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_id_r  <= '0;
      exp_src_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        icmp_rtt_pkg::REG_EXPECTED_ID:     exp_id_r  <= cfg_wdata[icmp_rtt_pkg::ID_W-1:0];
        icmp_rtt_pkg::REG_EXPECTED_SOURCE: exp_src_r <= cfg_wdata[icmp_rtt_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Check the reply in priority order; borrow a second when needed
  always_comb begin
    if (job.too_short) begin
      verdict2_nxt = icmp_rtt_pkg::VERDICT_SHORT;
    end else if (job.reply_type != icmp_rtt_pkg::ICMP_ECHO_REPLY) begin
      verdict2_nxt = icmp_rtt_pkg::VERDICT_TYPE;
    end else if (job.reply_id != exp_id_r) begin
      verdict2_nxt = icmp_rtt_pkg::VERDICT_ID;
    end else if (job.source != exp_src_r) begin
      verdict2_nxt = icmp_rtt_pkg::VERDICT_SRC;
    end else begin
      verdict2_nxt = icmp_rtt_pkg::VERDICT_OK;
    end

    us_diff = {1'b0, job.recv_usec} - {1'b0, job.sent_usec};
    us2_nxt = us_diff[icmp_rtt_pkg::US_W] ?
              us_diff + (icmp_rtt_pkg::US_W+1)'(icmp_rtt_pkg::USEC_PER_SEC) : us_diff;
    s2_nxt  = {2'b00, job.recv_sec} - {2'b00, job.sent_sec} -
              (icmp_rtt_pkg::SEC_W+2)'(us_diff[icmp_rtt_pkg::US_W]);
  end

  // Scale seconds; divide the microsecond magnitude by reciprocal
  always_comb begin
    s1000_nxt = {{(icmp_rtt_pkg::MS_W-icmp_rtt_pkg::SEC_W-2){s2_r[icmp_rtt_pkg::SEC_W+1]}},
                 s2_r} * icmp_rtt_pkg::MS_W'(icmp_rtt_pkg::MS_PER_SEC);
    us_neg    = ~us2_r + 1'b1;
    us_mag    = us2_r[icmp_rtt_pkg::US_W] ? us_neg[icmp_rtt_pkg::US_W-1:0]
                                          : us2_r[icmp_rtt_pkg::US_W-1:0];
    qp_nxt    = icmp_rtt_pkg::QP_W'(us_mag) *
                icmp_rtt_pkg::QP_W'(icmp_rtt_pkg::USEC_RECIP);
  end

  // Truncate toward zero, add, clamp to 32 bits
  always_comb begin
    q     = qp_r[icmp_rtt_pkg::RECIP_SHIFT +: icmp_rtt_pkg::Q_W];
    q_ext = icmp_rtt_pkg::MS_W'(q);
    q_s   = neg3_r ? (~q_ext + 1'b1) : q_ext;
    ms    = s1000_r + q_s;

    res_nxt.verdict = verdict3_r;
    if (verdict3_r != icmp_rtt_pkg::VERDICT_OK || ms[icmp_rtt_pkg::MS_W-1]) begin
      res_nxt.rtt = '0;
    end else if (|ms[icmp_rtt_pkg::MS_W-2:icmp_rtt_pkg::RTT_W]) begin
      res_nxt.rtt = '1;
    end else begin
      res_nxt.rtt = ms[icmp_rtt_pkg::RTT_W-1:0];
    end
  end

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (ready2) v2_r <= job_valid;
      if (ready3) v3_r <= v2_r;
      if (ready4) res_valid_r <= v3_r;
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk) begin
    if (ready2 && job_valid) begin
      verdict2_r <= verdict2_nxt;
      s2_r       <= s2_nxt;
      us2_r      <= us2_nxt;
    end
    if (ready3 && v2_r) begin
      verdict3_r <= verdict2_r;
      s1000_r    <= s1000_nxt;
      qp_r       <= qp_nxt;
      neg3_r     <= us2_r[icmp_rtt_pkg::US_W];
    end
    if (ready4 && v3_r) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/icmp_rtt_stats.sv
// ----------------------------------------------------------------------------
// icmp_rtt_stats
// Running min, max, total and count; result register of the block.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp_rtt_stats (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             res_valid,
  input  wire icmp_rtt_pkg::res_t               res,
  output logic                                  res_ready,
  output logic                                  out_valid_r,
  input  wire logic                             out_ready,
  output icmp_rtt_pkg::verdict_t                out_verdict_r,
  output logic [icmp_rtt_pkg::RTT_W-1:0]        out_rtt_r,
  output logic [icmp_rtt_pkg::RTT_W-1:0]        out_min_r,
  output logic [icmp_rtt_pkg::RTT_W-1:0]        out_max_r,
  output logic [icmp_rtt_pkg::TOTAL_W-1:0]      out_total_r,
  output logic [icmp_rtt_pkg::COUNT_W-1:0]      out_count_r,
  output logic                                  out_stats_valid_r
);

  logic [icmp_rtt_pkg::RTT_W-1:0]   min_r, min_nxt;
  logic [icmp_rtt_pkg::RTT_W-1:0]   max_r, max_nxt;
  logic [icmp_rtt_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic [icmp_rtt_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [icmp_rtt_pkg::TOTAL_W:0]   sum;
  logic                             take;

  assign res_ready = !out_valid_r || out_ready;
  assign take      = res_ready && res_valid;

  // Fold an accepted round trip into the statistics
  always_comb begin
    min_nxt   = min_r;
    max_nxt   = max_r;
    total_nxt = total_r;
    count_nxt = count_r;
    sum       = {1'b0, total_r} + (icmp_rtt_pkg::TOTAL_W+1)'(res.rtt);
    if (res.verdict == icmp_rtt_pkg::VERDICT_OK) begin
      if (count_r == '0) begin
        min_nxt = res.rtt;
        max_nxt = res.rtt;
      end else begin
        if (res.rtt < min_r) min_nxt = res.rtt;
        if (res.rtt > max_r) max_nxt = res.rtt;
      end
      total_nxt = sum[icmp_rtt_pkg::TOTAL_W] ? '1 : sum[icmp_rtt_pkg::TOTAL_W-1:0];
      if (count_r != '1) count_nxt = count_r + 1'b1;
    end
  end

  // Hold statistics and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r       <= '0;
      max_r       <= '0;
      total_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        min_r   <= min_nxt;
        max_r   <= max_nxt;
        total_r <= total_nxt;
        count_r <= count_nxt;
      end
      if (res_ready) out_valid_r <= res_valid;
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (take) begin
      out_verdict_r     <= res.verdict;
      out_rtt_r         <= res.rtt;
      out_min_r         <= min_nxt;
      out_max_r         <= max_nxt;
      out_total_r       <= total_nxt;
      out_count_r       <= count_nxt;
      out_stats_valid_r <= count_nxt != '0;
    end
  end

endmodule

`default_nettype wire

### hdl/icmp_echo_reply_rtt_stats.sv
// ----------------------------------------------------------------------------
// icmp_echo_reply_rtt_stats
// Checks received IPv4 ICMP echo replies and keeps round-trip statistics.
//
//   channel  dir  handshake         content
//   in_      in   tvalid/tready     one packet byte per word, tlast on final
//   out_     out  tvalid/tready     one verdict and statistics per packet
//   cfg_     in   we                expected identifier / source address
//
// One byte is taken per cycle with no gaps between packets unless a packet
// waits in the parse register. The result of a packet passes through the parse
// register, check stage, multiply stage, clamp stage and the statistics/result
// register. Every stage has its own valid and moves when the next stage is
// free, so input keeps flowing while a result waits until every stage is full.
// Reset clears all captured fields, statistics and the match registers.
// ----------------------------------------------------------------------------
`default_nettype none

module icmp_echo_reply_rtt_stats (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // packet_byte [7:0], recv_seconds [39:8], recv_microseconds [59:40]
  input  wire logic [icmp_rtt_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                                 in_tlast,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // rtt_ms [31:0], min_rtt_ms [63:32], max_rtt_ms [95:64],
  // total_rtt_ms [143:96], accepted_count [175:144]
  output logic [icmp_rtt_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // verdict [2:0], stats_valid [3]
  output logic [icmp_rtt_pkg::OUT_TUSER_W-1:0]      out_tuser,
  input  wire logic                                 cfg_we,
  input  wire logic [icmp_rtt_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [icmp_rtt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic                                job_valid, job_ready;
  icmp_rtt_pkg::job_t                  job;
  logic                                res_valid, res_ready;
  icmp_rtt_pkg::res_t                  res;
  icmp_rtt_pkg::verdict_t              out_verdict;
  logic [icmp_rtt_pkg::RTT_W-1:0]      out_rtt, out_min, out_max;
  logic [icmp_rtt_pkg::TOTAL_W-1:0]    out_total;
  logic [icmp_rtt_pkg::COUNT_W-1:0]    out_count;
  logic                                out_stats_valid;

  icmp_rtt_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_byte     (in_tdata[7:0]),
    .in_last     (in_tlast),
    .in_sec      (in_tdata[39:8]),
    .in_usec     (in_tdata[59:40]),
    .in_ready    (in_tready),
    .job_valid_r (job_valid),
    .job_r       (job),
    .job_ready   (job_ready)
  );

  icmp_rtt_calc u_calc (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .job_valid   (job_valid),
    .job         (job),
    .job_ready   (job_ready),
    .res_valid_r (res_valid),
    .res_r       (res),
    .res_ready   (res_ready)
  );

  icmp_rtt_stats u_stats (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (res_valid),
    .res               (res),
    .res_ready         (res_ready),
    .out_valid_r       (out_tvalid),
    .out_ready         (out_tready),
    .out_verdict_r     (out_verdict),
    .out_rtt_r         (out_rtt),
    .out_min_r         (out_min),
    .out_max_r         (out_max),
    .out_total_r       (out_total),
    .out_count_r       (out_count),
    .out_stats_valid_r (out_stats_valid)
  );

  // Pack the result word
  assign out_tdata = {out_count, out_total, out_max, out_min, out_rtt};
  assign out_tuser = {out_stats_valid, out_verdict};

endmodule

`default_nettype wire

### tb/sv/icmp_rtt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// icmp_rtt_checker
// Watches the byte, result and register ports of the ICMP echo-reply RTT
// block. Every accepted byte is run through a cycle-free model of the packet
// parser and statistics; each packet end queues the verdict and statistics
// it should produce, and every result word is compared field by field with
// the oldest queued entry.
// ----------------------------------------------------------------------------

module icmp_rtt_checker
  import icmp_rtt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // packet_byte [7:0], recv_seconds [39:8], recv_microseconds [59:40]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // rtt_ms [31:0], min_rtt_ms [63:32], max_rtt_ms [95:64],
  // total_rtt_ms [143:96], accepted_count [175:144]
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  // verdict [2:0], stats_valid [3]
  input  logic [OUT_TUSER_W-1:0] out_tuser,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     mismatches,
  output int                     outstanding
);

  localparam longint RTT_CEIL  = 64'sd4294967295;

  typedef struct {
    verdict_t           verdict;
    logic [RTT_W-1:0]   rtt_ms;
    logic [RTT_W-1:0]   min_ms;
    logic [RTT_W-1:0]   max_ms;
    logic [TOTAL_W-1:0] total_ms;
    logic [COUNT_W-1:0] count;
    logic               stats_valid;
  } reply_result_t;

  reply_result_t expected_replies[$];

  // match registers
  logic [ID_W-1:0]   want_id;
  logic [ADDR_W-1:0] want_src;

  // per-packet capture
  logic [POS_W-1:0]  byte_pos;
  logic [HDR_W-1:0]  hdr_len;
  logic [7:0]        reply_type;
  logic [ID_W-1:0]   reply_id;
  logic [ADDR_W-1:0] src_addr;
  logic [SEC_W-1:0]  sent_sec;
  logic [US_W-1:0]   sent_usec;

  // running statistics
  logic [RTT_W-1:0]   min_ms;
  logic [RTT_W-1:0]   max_ms;
  logic [TOTAL_W-1:0] total_ms;
  logic [COUNT_W-1:0] accepted;

  // Round trip in ms: borrow a second when the microseconds go negative,
  // truncate toward zero, clamp below at 0 and above at 32 bits.
  function automatic logic [RTT_W-1:0] round_trip_ms(input logic [SEC_W-1:0] rs,
                                                     input logic [US_W-1:0] rus);
    longint us, s, ms;
    us = longint'(rus) - longint'(sent_usec);
    s  = longint'(rs) - longint'(sent_sec);
    if (us < 0) begin
      s  = s - 1;
      us = us + 1000000;
    end
    ms = s * 1000 + us / 1000;
    if (ms < 0) return '0;
    if (ms > RTT_CEIL) return '1;
    return ms[RTT_W-1:0];
  endfunction

  // Advance the parser by one byte; on the last byte queue the packet result
  function automatic void predict_byte(input logic [7:0] b, input logic last,
                                       input logic [SEC_W-1:0] rs,
                                       input logic [US_W-1:0] rus);
    int unsigned   p, h, t0, u0, len, need;
    logic [23:0]   usec_bytes;
    logic [TOTAL_W:0] sum;
    reply_result_t r;
    p = byte_pos;
    if (p == 0) hdr_len = {b[3:0], 2'b00};
    h  = hdr_len;
    t0 = h + OFF_SEC;
    u0 = t0 + TIME_FIELD_BYTES;

    // capture fields; a short header may overlap them with the IP header
    if (p >= SRC_FIRST && p <= SRC_LAST) src_addr[8*(SRC_LAST-p) +: 8] = b;
    if (p == h) reply_type = b;
    if (p == h + OFF_ID_LO) reply_id[7:0] = b;
    if (p == h + OFF_ID_HI) reply_id[15:8] = b;
    if (p >= t0 && p < u0 && p - t0 < SEC_BYTES) sent_sec[8*(p-t0) +: 8] = b;
    if (p >= u0 && p < u0 + TIME_FIELD_BYTES && p - u0 < USEC_BYTES) begin
      usec_bytes = {4'h0, sent_usec};
      usec_bytes[8*(p-u0) +: 8] = b;
      sent_usec = usec_bytes[US_W-1:0];
    end

    if (!last) begin
      // position sticks at its top on very long packets
      if (byte_pos != '1) byte_pos = byte_pos + 1'b1;
      return;
    end

    len      = p + 1;
    byte_pos = '0;
    need     = h + MIN_ICMP_BYTES;

    if (len < need)                       r.verdict = VERDICT_SHORT;
    else if (reply_type != ICMP_ECHO_REPLY) r.verdict = VERDICT_TYPE;
    else if (reply_id != want_id)         r.verdict = VERDICT_ID;
    else if (src_addr != want_src)        r.verdict = VERDICT_SRC;
    else                                  r.verdict = VERDICT_OK;

    r.rtt_ms = '0;
    if (r.verdict == VERDICT_OK) begin
      r.rtt_ms = round_trip_ms(rs, rus);
      if (accepted == 0) begin
        min_ms = r.rtt_ms;
        max_ms = r.rtt_ms;
      end else begin
        if (r.rtt_ms < min_ms) min_ms = r.rtt_ms;
        if (r.rtt_ms > max_ms) max_ms = r.rtt_ms;
      end
      sum      = {1'b0, total_ms} + r.rtt_ms;
      total_ms = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
      if (accepted != '1) accepted = accepted + 1'b1;
    end
    r.min_ms      = min_ms;
    r.max_ms      = max_ms;
    r.total_ms    = total_ms;
    r.count       = accepted;
    r.stats_valid = (accepted != 0);
    expected_replies.push_back(r);
  endfunction

  task automatic check_field(input string field, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    reply_result_t want;
    if (!rst_n) begin
      want_id   = '0;
      want_src  = '0;
      byte_pos  = '0;
      hdr_len   = '0;
      reply_type = '0;
      reply_id  = '0;
      src_addr  = '0;
      sent_sec  = '0;
      sent_usec = '0;
      min_ms    = '0;
      max_ms    = '0;
      total_ms  = '0;
      accepted  = '0;
      expected_replies.delete();
    end else begin
      // compare a delivered result with the oldest expectation
      if (out_tvalid && out_tready) begin
        if (expected_replies.size() == 0) begin
          mismatches++;
          $display("%0t: result word expected none, got verdict %0d rtt %0d",
                   $time, out_tuser[2:0], out_tdata[31:0]);
        end else begin
          want = expected_replies.pop_front();
          check_field("verdict", want.verdict, out_tuser[2:0]);
          check_field("rtt_ms", want.rtt_ms, out_tdata[31:0]);
          check_field("min_rtt_ms", want.min_ms, out_tdata[63:32]);
          check_field("max_rtt_ms", want.max_ms, out_tdata[95:64]);
          check_field("total_rtt_ms", want.total_ms, out_tdata[143:96]);
          check_field("accepted_count", want.count, out_tdata[175:144]);
          check_field("stats_valid", want.stats_valid, out_tuser[3]);
        end
      end

      // track register writes
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_EXPECTED_ID:     want_id  = cfg_wdata[ID_W-1:0];
          REG_EXPECTED_SOURCE: want_src = cfg_wdata[ADDR_W-1:0];
          default: ;
        endcase
      end

      if (in_tvalid && in_tready)
        predict_byte(in_tdata[7:0], in_tlast, in_tdata[39:8], in_tdata[59:40]);
    end
    outstanding <= expected_replies.size();
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the ICMP echo-reply RTT block. Sends hand-built
// IPv4/ICMP packets one byte per word: a directed set covering lengths,
// header sizes, every verdict and the round-trip corner cases, then random
// reply traffic under several match settings, with random gaps on both
// sides, a no-gap stretch and a long result stall. The checker does the
// prediction and comparison.
// ----------------------------------------------------------------------------

module tb;
  import icmp_rtt_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 200;
  localparam int IDLE_PCT      = 34;
  localparam int RAND_BYTES    = 800;
  localparam int RAND_PACKETS  = 30;

  logic                   clk;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                   in_tlast  = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr  = REG_EXPECTED_ID;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int mismatches;
  int pending;

  // receiver control; rate and hold requests written by the stimulus process
  int rx_idle_pct   = IDLE_PCT;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  int tx_idle_pct = IDLE_PCT;
  int bytes_sent  = 0;

  logic [ID_W-1:0]   cur_id  = '0;
  logic [ADDR_W-1:0] cur_src = '0;
  logic [7:0]        frame[$];

  icmp_echo_reply_rtt_stats DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  icmp_rtt_checker rtt_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    #1_000_000;
    $display("FAIL icmp_echo_reply_rtt_stats");
    $finish;
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_EXPECTED_ID:     cur_id  = value[ID_W-1:0];
      REG_EXPECTED_SOURCE: cur_src = value;
      default: ;
    endcase
  endtask

  task automatic set_match(input logic [ID_W-1:0] id, input logic [ADDR_W-1:0] src);
    write_reg(REG_EXPECTED_ID, CFG_DATA_W'(id));
    write_reg(REG_EXPECTED_SOURCE, src);
  endtask

  // Stop sending and hold until every expected result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one word after a random gap and hold it until accepted
  task automatic push_byte(input logic [7:0] b, input logic last,
                           input logic [SEC_W-1:0] rs, input logic [US_W-1:0] rus);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'h0, rus, rs, b};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  function automatic void put_byte(input int idx, input logic [7:0] value);
    if (idx < frame.size()) frame[idx] = value;
  endfunction

  // Random bytes with IHL, source, type, identifier and timestamps laid in
  function automatic void build_frame(input int ihl, input int n, input logic [7:0] msg_type,
                                      input logic [ID_W-1:0] ident,
                                      input logic [ADDR_W-1:0] src,
                                      input logic [SEC_W-1:0] sent_s,
                                      input logic [US_W-1:0] sent_us);
    int          h;
    logic [63:0] sec_field, usec_field;
    logic [7:0]  first;
    h          = ihl * 4;
    sec_field  = {$urandom, sent_s};
    usec_field = {$urandom, $urandom};
    usec_field[US_W-1:0] = sent_us;
    frame.delete();
    repeat (n) frame.push_back(8'($urandom));
    if (n > 0) begin
      first      = frame[0];
      first[3:0] = 4'(ihl);
      frame[0]   = first;
    end
    for (int i = 0; i < 4; i++) put_byte(SRC_FIRST + i, src[31-8*i -: 8]);
    put_byte(h + OFF_TYPE, msg_type);
    put_byte(h + OFF_ID_LO, ident[7:0]);
    put_byte(h + OFF_ID_HI, ident[15:8]);
    for (int i = 0; i < TIME_FIELD_BYTES; i++) begin
      put_byte(h + OFF_SEC + i, sec_field[8*i +: 8]);
      put_byte(h + OFF_USEC + i, usec_field[8*i +: 8]);
    end
  endfunction

  // Send the built frame; the receive time only matters on the last word
  task automatic send_frame(input logic [SEC_W-1:0] rs, input logic [US_W-1:0] rus);
    for (int i = 0; i < frame.size(); i++) begin
      if (i == frame.size() - 1) push_byte(frame[i], 1'b1, rs, rus);
      else push_byte(frame[i], 1'b0, $urandom, 20'($urandom));
    end
  endtask

  task automatic send_reply(input int ihl, input int n, input logic [7:0] msg_type,
                            input logic [ID_W-1:0] ident, input logic [ADDR_W-1:0] src,
                            input logic [SEC_W-1:0] sent_s, input logic [US_W-1:0] sent_us,
                            input logic [SEC_W-1:0] rs, input logic [US_W-1:0] rus);
    build_frame(ihl, n, msg_type, ident, src, sent_s, sent_us);
    send_frame(rs, rus);
  endtask

  task automatic send_one_byte(input logic [7:0] b);
    frame.delete();
    frame.push_back(b);
    send_frame($urandom, 20'($urandom));
  endtask

  // Mostly well-formed replies; some wrong type, id, source, short or noise
  task automatic send_random_packet();
    int                kind, ihl, n, delay;
    logic [7:0]        rtype;
    logic [ID_W-1:0]   rid;
    logic [ADDR_W-1:0] rsrc;
    logic [SEC_W-1:0]  sent_s, recv_s;
    logic [US_W-1:0]   sent_us, recv_us;
    kind = $urandom_range(99);
    if ($urandom_range(9) == 0) ihl = $urandom_range(15);
    else if ($urandom_range(3) == 0) ihl = $urandom_range(5, 15);
    else ihl = 5;
    n     = ihl * 4 + MIN_ICMP_BYTES + $urandom_range(6);
    rtype = ICMP_ECHO_REPLY;
    rid   = cur_id;
    rsrc  = cur_src;
    if (kind < 10) rtype = 8'($urandom_range(1, 255));
    else if (kind < 18) rid = cur_id ^ ID_W'($urandom_range(1, 65535));
    else if (kind < 26) rsrc = cur_src ^ (32'd1 << $urandom_range(31));
    else if (kind < 34) n = $urandom_range(1, ihl * 4 + MIN_ICMP_BYTES - 1);
    else if (kind < 40) n = $urandom_range(1, 70);

    sent_s  = $urandom;
    sent_us = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(999999));
    recv_us = 20'($urandom_range(999999));
    delay   = $urandom_range(9);
    if (delay < 6) recv_s = sent_s + $urandom_range(3);
    else if (delay == 6) recv_s = sent_s - $urandom_range(2);
    else if (delay == 7) recv_s = $urandom;
    else if (delay == 8) recv_s = sent_s + $urandom_range(4294966, 4294968);
    else begin
      recv_s  = sent_s + $urandom_range(1);
      recv_us = 20'($urandom);
    end

    build_frame(ihl, n, rtype, rid, rsrc, sent_s, sent_us);
    if (kind >= 34 && kind < 40) begin
      foreach (frame[i]) frame[i] = 8'($urandom);
    end
    send_frame(recv_s, recv_us);
  endtask

  initial begin
    int rand_start;
    int rand_packets;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, match registers at their reset value
    send_reply(5, 44, ICMP_ECHO_REPLY, 16'h0000, 32'h0, 32'd100, 20'd500000,
               32'd100, 20'd750000);                        // exact minimum length
    send_reply(5, 43, ICMP_ECHO_REPLY, 16'h0000, 32'h0, 32'd100, 20'd0,
               32'd101, 20'd0);                             // one byte short
    send_reply(5, 25, ICMP_ECHO_REPLY, 16'h0000, 32'h0, 32'd1, 20'd0,
               32'd2, 20'd0);                               // ICMP part under 8
    send_one_byte(8'hFF);
    send_one_byte(8'h00);
    send_reply(5, 50, 8'd8, 16'h0000, 32'h0, 32'd7, 20'd0, 32'd8, 20'd0);
    send_reply(5, 44, 8'hFF, 16'h0000, 32'h0, 32'd7, 20'd0, 32'd8, 20'd0);
    send_reply(5, 44, ICMP_ECHO_REPLY, 16'h0001, 32'h0, 32'd7, 20'd0, 32'd8, 20'd0);
    send_reply(5, 44, ICMP_ECHO_REPLY, 16'h0000, 32'h8000_0000, 32'd7, 20'd0,
               32'd8, 20'd0);
    drain();

    // Directed, all-ones match registers
    set_match(16'hFFFF, 32'hFFFF_FFFF);
    send_reply(15, 84, ICMP_ECHO_REPLY, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               20'd999999, 32'hFFFF_FFFF, 20'd999999);       // longest header, zero rtt
    send_reply(5, 44, ICMP_ECHO_REPLY, 16'hFFFF, 32'hFFFF_FFFF, 32'd50, 20'd0,
               32'd49, 20'd0);                              // negative, clamps
    send_reply(5, 60, ICMP_ECHO_REPLY, 16'hFFFF, 32'hFFFF_FFFF, 32'd5, 20'd900000,
               32'd7, 20'd100000);                          // microsecond borrow
    send_reply(5, 44, ICMP_ECHO_REPLY, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, 20'd0,
               32'hFFFF_FFFF, 20'd0);                       // saturates
    send_reply(5, 44, ICMP_ECHO_REPLY, 16'hFFFF, 32'hFFFF_FFFF, 32'd10, 20'd0,
               32'd10, 20'hFFFFF);                          // receive usec out of range
    send_reply(5, 44, ICMP_ECHO_REPLY, 16'hFFFF, 32'hFFFF_FFFF, 32'd10, 20'hFFFFF,
               32'd12, 20'd0);                              // sent usec out of range
    send_reply(0, 40, ICMP_ECHO_REPLY, 16'hFFFF, 32'hFFFF_FFFF, 32'd3, 20'd0,
               32'd4, 20'd0);                               // empty header
    send_reply(3, 40, ICMP_ECHO_REPLY, 16'hFFFF, 32'hFFFF_FFFF, 32'd3, 20'd0,
               32'd4, 20'd0);                               // header overlaps source
    drain();

    // Random traffic with gaps on both sides
    rand_start   = bytes_sent;
    rand_packets = 0;
    set_match(ID_W'($urandom), $urandom);
    repeat (5) begin
      send_random_packet();
      rand_packets++;
    end
    drain();

    // No idling on either side
    set_match(16'h0000, 32'h0000_0000);
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    repeat (8) begin
      send_random_packet();
      rand_packets++;
    end
    drain();

    // Long result stall while short packets keep coming
    set_match(ID_W'($urandom), $urandom);
    tx_idle_pct = IDLE_PCT;
    rx_idle_pct <= IDLE_PCT;
    hold_requests <= hold_requests + 1;
    repeat (16) begin
      build_frame($urandom_range(15), $urandom_range(1, 3), 8'($urandom), 16'($urandom),
                  $urandom, $urandom, 20'($urandom));
      send_frame($urandom, 20'($urandom));
      rand_packets++;
    end
    repeat (4) begin
      send_random_packet();
      rand_packets++;
    end
    drain();

    // Remaining random traffic under another setting
    set_match(ID_W'($urandom), $urandom);
    while (rand_packets < RAND_PACKETS || bytes_sent - rand_start < RAND_BYTES) begin
      send_random_packet();
      rand_packets++;
    end
    drain();

    if (mismatches == 0 && pending == 0) begin
      $display("PASS icmp_echo_reply_rtt_stats");
    end else begin
      $display("FAIL icmp_echo_reply_rtt_stats");
    end
    $finish;
  end

endmodule
